// File: src/plpl_pkg.sv
package plpl_pkg;

    localparam int FIELD_W = 40;
    localparam int CMD_W   = 3;
    localparam int STS_W   = 3;

    // datapath widths, all derived from the field width
    localparam int DIFF_W  = FIELD_W + 1;        // difference of two fields
    localparam int MAG_W   = FIELD_W;            // magnitude of such a difference
    localparam int ROOT_W  = FIELD_W + 1;        // root, quotient, divisor
    localparam int PROD_W  = 2 * FIELD_W + 2;    // product / radicand shift register
    localparam int SQ_W    = 2 * FIELD_W;        // one square
    localparam int REM_W   = FIELD_W + 4;        // partial remainder

    localparam int MUL_STEPS  = MAG_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = ROOT_W;
    localparam int CNT_W      = 6;

    localparam logic signed [FIELD_W-1:0] ARC_LIMIT = {1'b0, {(FIELD_W-1){1'b1}}};

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RADIUS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ARC     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POINT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TANGENT = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NORMAL  = 3'd6;

    localparam logic [STS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STS_W-1:0] STS_RANGE    = 3'd1;
    localparam logic [STS_W-1:0] STS_NOT_INC  = 3'd2;
    localparam logic [STS_W-1:0] STS_FULL     = 3'd3;
    localparam logic [STS_W-1:0] STS_TOO_FEW  = 3'd4;
    localparam logic [STS_W-1:0] STS_BAD_CMD  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RDL,
        S_RANGE,
        S_SRCH,
        S_CMP,
        S_SEG0,
        S_SEG1,
        S_SEGD,
        S_MUL,
        S_SQADD,
        S_SQRT,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

endpackage

// File: src/piecewise_linear_profile_lookup_core.sv
// Piecewise-linear profile table: up to MAX_POINTS (z, r) points with running arc length.
// Command channel: raise start with i_cmd and the operand ports; the word is taken at a
// rising edge where start is high and busy is low. busy stays high until the result
// has been shown. Result channel: o_valid is high for exactly one cycle with o_status,
// o_value_first and o_value_second; the receiver cannot stall it.
// Per word: clear, bad command and early errors go straight to the result. Queries run
// a binary search over the table (one table read per probe), plus the arithmetic on
// one shared 82-bit add/subtract unit at one bit per cycle: radius/arc at z use a
// multiply and a divide, point at arc two of each, tangent and normal two 40-step
// squares, a 41-step root and two 41-step divides, append two squares and a root.
// The next word is accepted the cycle after the result strobe.
// Reset empties the table (point count zero); the stores themselves are not cleared,
// entries above the count are never read.
module piecewise_linear_profile_lookup_core #(
    parameter int MAX_POINTS = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [plpl_pkg::CMD_W-1:0]            i_cmd,
    input  logic signed [plpl_pkg::FIELD_W-1:0]   i_coord_z,
    input  logic signed [plpl_pkg::FIELD_W-1:0]   i_coord_r,
    input  logic signed [plpl_pkg::FIELD_W-1:0]   i_query_key,
    output logic                                  o_valid,
    output logic [plpl_pkg::STS_W-1:0]            o_status,
    output logic signed [plpl_pkg::FIELD_W-1:0]   o_value_first,
    output logic signed [plpl_pkg::FIELD_W-1:0]   o_value_second
);
    import plpl_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);

    function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [FIELD_W-1:0] a,
                                                       input logic signed [FIELD_W-1:0] b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] abs_v;
        abs_v = v[DIFF_W-1] ? -v : v;
        return abs_v[MAG_W-1:0];
    endfunction

    // stores
    logic signed [FIELD_W-1:0] mem_z [MAX_POINTS];
    logic signed [FIELD_W-1:0] mem_r [MAX_POINTS];
    logic signed [FIELD_W-1:0] mem_a [MAX_POINTS];

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic signed [FIELD_W-1:0] mem_wz, mem_wr, mem_wa;
    logic [AW-1:0]             rd_addr;
    logic signed [FIELD_W-1:0] r_rd_z, r_rd_r, r_rd_a;

    // control
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;

    // payload
    logic [CMD_W-1:0]          r_cmd, n_cmd;
    logic signed [FIELD_W-1:0] r_cz, n_cz, r_cr, n_cr, r_key, n_key;
    logic [CW-1:0]             r_lo, n_lo, r_hi, n_hi;
    logic [AW-1:0]             r_seg, n_seg;
    logic signed [FIELD_W-1:0] r_zf, n_zf;
    logic signed [FIELD_W-1:0] r_z0, n_z0, r_r0, n_r0, r_a0, n_a0, r_r1, n_r1;
    logic signed [DIFF_W-1:0]  r_dz, n_dz, r_dr, n_dr;
    logic [MAG_W-1:0]          r_num, n_num, r_mag, n_mag, r_mulb, n_mulb;
    logic [ROOT_W-1:0]         r_den, n_den, r_root, n_root;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [SQ_W-1:0]           r_sq, n_sq;
    logic [REM_W-1:0]          r_rem, n_rem;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_pass, n_pass, r_neg, n_neg;
    logic signed [FIELD_W-1:0] r_base, n_base;
    logic [STS_W-1:0]          r_status, n_status;
    logic signed [FIELD_W-1:0] r_v1, n_v1, r_v2, n_v2;

    // shared add/subtract unit
    logic [PROD_W-1:0] au_a, au_b;
    logic              au_sub;
    logic [PROD_W:0]   au_res;
    logic              au_ge;

    // helpers
    logic [CW:0]               mid_sum;
    logic [CW-1:0]             mid, lo_c, seg_full;
    logic signed [FIELD_W-1:0] probe;
    logic signed [DIFF_W-1:0]  seg_num, seg_den, seg_delta, num_c;
    logic signed [FIELD_W-1:0] seg_base;
    logic                      lerp_skip, hyp_job, last_step;
    logic [REM_W-1:0]          rem_sh;
    logic [REM_W-2:0]          trial;
    logic [ROOT_W:0]           div_sh;
    logic [ROOT_W-1:0]         root_new;
    logic [PROD_W-1:0]         tan_num;
    logic signed [FIELD_W+1:0] fin_ext;
    logic signed [FIELD_W-1:0] fin_val;
    logic [DIFF_W-1:0]         room, arc_sum;
    logic signed [FIELD_W-1:0] arc_new;

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_status       = r_status;
    assign o_value_first  = r_v1;
    assign o_value_second = r_v2;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_z[mem_waddr] <= mem_wz;
            mem_r[mem_waddr] <= mem_wr;
            mem_a[mem_waddr] <= mem_wa;
        end
        r_rd_z <= mem_z[rd_addr];
        r_rd_r <= mem_r[rd_addr];
        r_rd_a <= mem_a[rd_addr];
    end

    always_comb begin
        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b0;
        unique case (r_state)
            S_MUL: begin
                au_a = r_prod << 1;
                au_b = r_mulb[MAG_W-1] ? PROD_W'(r_mag) : '0;
            end
            S_SQADD: begin
                au_a = r_prod;
                au_b = PROD_W'(r_sq);
            end
            S_SQRT: begin
                au_a   = PROD_W'(rem_sh);
                au_b   = PROD_W'(trial);
                au_sub = 1'b1;
            end
            S_DIV: begin
                au_a   = PROD_W'(div_sh);
                au_b   = PROD_W'(r_den);
                au_sub = 1'b1;
            end
            default: begin
            end
        endcase
        au_res = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)} + (PROD_W+1)'(au_sub);
        au_ge  = au_res[PROD_W];
    end

    always_comb begin
        mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
        mid      = mid_sum[CW:1];
        probe    = (r_cmd == CMD_RADIUS || r_cmd == CMD_ARC) ? r_rd_z : r_rd_a;
        if (r_lo == '0)
            lo_c = CW'(1);
        else if (r_lo > r_count - CW'(1))
            lo_c = r_count - CW'(1);
        else
            lo_c = r_lo;
        seg_full = lo_c - CW'(1);

        case (r_cmd)
            CMD_RADIUS: begin
                seg_num   = sdiff(r_key, r_z0);
                seg_den   = sdiff(r_rd_z, r_z0);
                seg_delta = sdiff(r_rd_r, r_r0);
                seg_base  = r_r0;
            end
            CMD_ARC: begin
                seg_num   = sdiff(r_key, r_z0);
                seg_den   = sdiff(r_rd_z, r_z0);
                seg_delta = sdiff(r_rd_a, r_a0);
                seg_base  = r_a0;
            end
            default: begin
                seg_num   = sdiff(r_key, r_a0);
                seg_den   = sdiff(r_rd_a, r_a0);
                seg_delta = sdiff(r_rd_z, r_z0);
                seg_base  = r_z0;
            end
        endcase
        lerp_skip = (seg_den <= 0) || (seg_num <= 0);
        num_c     = (seg_num > seg_den) ? seg_den : seg_num;

        hyp_job   = (r_cmd == CMD_APPEND) || (r_cmd == CMD_TANGENT) || (r_cmd == CMD_NORMAL);
        last_step = (r_cnt == '0);

        rem_sh   = {r_rem[REM_W-3:0], r_prod[PROD_W-1 -: 2]};
        trial    = {r_root, 2'b01};
        div_sh   = {r_rem[ROOT_W-1:0], r_prod[ROOT_W-1]};
        root_new = {r_root[ROOT_W-2:0], au_ge};
        tan_num  = PROD_W'(mag_of(r_state == S_FIN ? r_dr : r_dz)) << FRAC_BITS;

        fin_ext = (FIELD_W+2)'(r_base)
                + (r_neg ? -(FIELD_W+2)'({1'b0, r_root}) : (FIELD_W+2)'({1'b0, r_root}));
        fin_val = fin_ext[FIELD_W-1:0];

        room    = DIFF_W'(ARC_LIMIT) - DIFF_W'(r_a0);
        arc_sum = DIFF_W'(r_a0) + r_root;
        arc_new = (r_root >= room) ? ARC_LIMIT : arc_sum[FIELD_W-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cmd    = r_cmd;
        n_cz     = r_cz;
        n_cr     = r_cr;
        n_key    = r_key;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_seg    = r_seg;
        n_zf     = r_zf;
        n_z0     = r_z0;
        n_r0     = r_r0;
        n_a0     = r_a0;
        n_r1     = r_r1;
        n_dz     = r_dz;
        n_dr     = r_dr;
        n_num    = r_num;
        n_mag    = r_mag;
        n_mulb   = r_mulb;
        n_den    = r_den;
        n_root   = r_root;
        n_prod   = r_prod;
        n_sq     = r_sq;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_pass   = r_pass;
        n_neg    = r_neg;
        n_base   = r_base;
        n_status = r_status;
        n_v1     = r_v1;
        n_v2     = r_v2;
        rd_addr   = '0;
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wz    = r_cz;
        mem_wr    = r_cr;
        mem_wa    = arc_new;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_cz     = i_coord_z;
                    n_cr     = i_coord_r;
                    n_key    = i_query_key;
                    n_status = STS_OK;
                    n_v1     = '0;
                    n_v2     = '0;
                    n_state  = S_OUT;
                    unique case (i_cmd)
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_APPEND: begin
                            if (r_count >= CW'(MAX_POINTS)) begin
                                n_status = STS_FULL;
                            end else if (r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wz    = i_coord_z;
                                mem_wr    = i_coord_r;
                                mem_wa    = '0;
                                n_count   = CW'(1);
                            end else begin
                                n_state = S_RDL;
                            end
                        end
                        CMD_RADIUS, CMD_ARC, CMD_POINT, CMD_TANGENT, CMD_NORMAL: begin
                            if (r_count < CW'(2))
                                n_status = STS_TOO_FEW;
                            else
                                n_state = S_RD0;
                        end
                        default: begin
                            n_status = STS_BAD_CMD;
                        end
                    endcase
                end
            end
            S_RD0: begin
                rd_addr = '0;
                n_state = S_RDL;
            end
            S_RDL: begin
                rd_addr = AW'(r_count - CW'(1));
                n_zf    = r_rd_z;
                n_state = S_RANGE;
            end
            S_RANGE: begin
                // read data is the last point
                n_lo    = '0;
                n_hi    = r_count;
                n_state = S_SRCH;
                unique case (r_cmd)
                    CMD_APPEND: begin
                        if (r_cz <= r_rd_z) begin
                            n_status = STS_NOT_INC;
                            n_state  = S_OUT;
                        end else begin
                            n_dz    = sdiff(r_cz, r_rd_z);
                            n_dr    = sdiff(r_cr, r_rd_r);
                            n_a0    = r_rd_a;
                            n_mag   = mag_of(sdiff(r_cz, r_rd_z));
                            n_mulb  = mag_of(sdiff(r_cz, r_rd_z));
                            n_prod  = '0;
                            n_pass  = 1'b0;
                            n_cnt   = CNT_W'(MUL_STEPS - 1);
                            n_state = S_MUL;
                        end
                    end
                    CMD_RADIUS: begin
                        if (r_key < r_zf || r_key > r_rd_z) begin
                            n_status = STS_RANGE;
                            n_state  = S_OUT;
                        end
                    end
                    CMD_ARC: begin
                        if (r_key < r_zf)
                            n_key = r_zf;
                        else if (r_key > r_rd_z)
                            n_key = r_rd_z;
                    end
                    default: begin
                        if (r_key < 0)
                            n_key = '0;
                        else if (r_key > r_rd_a)
                            n_key = r_rd_a;
                    end
                endcase
            end
            S_SRCH: begin
                rd_addr = mid[AW-1:0];
                if (r_lo < r_hi) begin
                    n_state = S_CMP;
                end else begin
                    n_seg   = seg_full[AW-1:0];
                    n_state = S_SEG0;
                end
            end
            S_CMP: begin
                if (probe <= r_key)
                    n_lo = mid + CW'(1);
                else
                    n_hi = mid;
                n_state = S_SRCH;
            end
            S_SEG0: begin
                rd_addr = r_seg;
                n_state = S_SEG1;
            end
            S_SEG1: begin
                rd_addr = r_seg + AW'(1);
                n_z0    = r_rd_z;
                n_r0    = r_rd_r;
                n_a0    = r_rd_a;
                n_state = S_SEGD;
            end
            S_SEGD: begin
                n_r1 = r_rd_r;
                if (r_cmd == CMD_TANGENT || r_cmd == CMD_NORMAL) begin
                    n_dz    = sdiff(r_rd_z, r_z0);
                    n_dr    = sdiff(r_rd_r, r_r0);
                    n_mag   = mag_of(sdiff(r_rd_z, r_z0));
                    n_mulb  = mag_of(sdiff(r_rd_z, r_z0));
                    n_prod  = '0;
                    n_pass  = 1'b0;
                    n_cnt   = CNT_W'(MUL_STEPS - 1);
                    n_state = S_MUL;
                end else if (lerp_skip) begin
                    // zero-length segment or key at its start
                    n_v1    = seg_base;
                    n_v2    = (r_cmd == CMD_POINT) ? r_r0 : '0;
                    n_state = S_OUT;
                end else begin
                    n_num   = num_c[MAG_W-1:0];
                    n_mulb  = num_c[MAG_W-1:0];
                    n_den   = seg_den;
                    n_mag   = mag_of(seg_delta);
                    n_neg   = seg_delta[DIFF_W-1];
                    n_base  = seg_base;
                    n_prod  = '0;
                    n_pass  = 1'b0;
                    n_cnt   = CNT_W'(MUL_STEPS - 1);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // shift-add, multiplier msb first
                n_prod = au_res[PROD_W-1:0];
                n_mulb = r_mulb << 1;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last_step) begin
                    if (hyp_job) begin
                        if (!r_pass) begin
                            n_sq   = au_res[SQ_W-1:0];
                            n_mag  = mag_of(r_dr);
                            n_mulb = mag_of(r_dr);
                            n_prod = '0;
                            n_pass = 1'b1;
                            n_cnt  = CNT_W'(MUL_STEPS - 1);
                        end else begin
                            n_state = S_SQADD;
                        end
                    end else begin
                        n_rem   = REM_W'(au_res[PROD_W-1:ROOT_W]);
                        n_root  = '0;
                        n_cnt   = CNT_W'(DIV_STEPS - 1);
                        n_state = S_DIV;
                    end
                end
            end
            S_SQADD: begin
                n_prod  = au_res[PROD_W-1:0];
                n_rem   = '0;
                n_root  = '0;
                n_cnt   = CNT_W'(SQRT_STEPS - 1);
                n_state = S_SQRT;
            end
            S_SQRT: begin
                // restoring square root, two radicand bits per step
                n_rem  = au_ge ? au_res[REM_W-1:0] : rem_sh;
                n_root = root_new;
                n_prod = r_prod << 2;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last_step) begin
                    if (r_cmd == CMD_APPEND) begin
                        n_state = S_FIN;
                    end else if (root_new == '0) begin
                        n_v1    = '0;
                        n_v2    = '0;
                        n_state = S_OUT;
                    end else begin
                        n_den   = root_new;
                        n_prod  = tan_num;
                        n_rem   = REM_W'(tan_num[PROD_W-1:ROOT_W]);
                        n_root  = '0;
                        n_neg   = r_dz[DIFF_W-1];
                        n_base  = '0;
                        n_pass  = 1'b0;
                        n_cnt   = CNT_W'(DIV_STEPS - 1);
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // restoring divide, quotient known to fit ROOT_W bits
                n_rem  = au_ge ? REM_W'(au_res[ROOT_W:0]) : REM_W'(div_sh);
                n_root = root_new;
                n_prod = r_prod << 1;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last_step)
                    n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_OUT;
                case (r_cmd)
                    CMD_APPEND: begin
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        n_v1    = arc_new;
                    end
                    CMD_POINT: begin
                        if (!r_pass) begin
                            n_v1    = fin_val;
                            n_mag   = mag_of(sdiff(r_r1, r_r0));
                            n_neg   = sdiff(r_r1, r_r0) < 0;
                            n_base  = r_r0;
                            n_mulb  = r_num;
                            n_prod  = '0;
                            n_pass  = 1'b1;
                            n_cnt   = CNT_W'(MUL_STEPS - 1);
                            n_state = S_MUL;
                        end else begin
                            n_v2 = fin_val;
                        end
                    end
                    CMD_TANGENT, CMD_NORMAL: begin
                        if (!r_pass) begin
                            n_v1    = fin_val;
                            n_prod  = tan_num;
                            n_rem   = REM_W'(tan_num[PROD_W-1:ROOT_W]);
                            n_root  = '0;
                            n_neg   = r_dr[DIFF_W-1];
                            n_pass  = 1'b1;
                            n_cnt   = CNT_W'(DIV_STEPS - 1);
                            n_state = S_DIV;
                        end else if (r_cmd == CMD_TANGENT) begin
                            n_v2 = fin_val;
                        end else begin
                            n_v1 = fin_val;
                            n_v2 = -r_v1;
                        end
                    end
                    default: begin
                        n_v1 = fin_val;
                    end
                endcase
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cz     <= n_cz;
        r_cr     <= n_cr;
        r_key    <= n_key;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_seg    <= n_seg;
        r_zf     <= n_zf;
        r_z0     <= n_z0;
        r_r0     <= n_r0;
        r_a0     <= n_a0;
        r_r1     <= n_r1;
        r_dz     <= n_dz;
        r_dr     <= n_dr;
        r_num    <= n_num;
        r_mag    <= n_mag;
        r_mulb   <= n_mulb;
        r_den    <= n_den;
        r_root   <= n_root;
        r_prod   <= n_prod;
        r_sq     <= n_sq;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_pass   <= n_pass;
        r_neg    <= n_neg;
        r_base   <= n_base;
        r_status <= n_status;
        r_v1     <= n_v1;
        r_v2     <= n_v2;
    end

endmodule
